/* src/gclp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the grid lowest-point filter.
// Used by gclp_ctrl, gclp_dpath and grid_cell_lowest_point; depends on nothing.
package gclp_pkg;

    localparam int COORD_W = 32;

    // Item op codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_REPORT  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_CELL_SHIFT = 3'd2;
    localparam logic [2:0] CFG_GRID_COLS  = 3'd3;
    localparam logic [2:0] CFG_GRID_ROWS  = 3'd4;

    // Configuration reset values and limits
    localparam logic [4:0] SHIFT_RESET = 5'd8;
    localparam logic [4:0] MAX_SHIFT   = 5'd24;
    localparam logic [6:0] COLS_RESET  = 7'd64;
    localparam logic [6:0] ROWS_RESET  = 7'd64;

    // Controller to datapath
    typedef struct packed {
        logic clr;     // clear one memory entry, advance the sweep
        logic load;    // capture an accepted item
        logic calc;    // resolve cell index, range and centers
        logic finish;  // update the cell and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;  // sweep sits on the last entry
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage

/* src/gclp_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the grid lowest-point filter: clearing sweep, then one item at a time.
// Depends on gclp_pkg for the command and status structs.
module gclp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gclp_pkg::t_sts    i_sts,
    output logic              o_in_stall,
    output gclp_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CALC   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_CALC;
            end
            S_CALC:   n_state = S_READ;
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.clr    = (r_state == S_CLEAR);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.calc   = (r_state == S_CALC);
    assign o_cmd.finish = (r_state == S_UPDATE) && i_sts.out_free;

endmodule

/* src/gclp_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the grid lowest-point filter: config registers, cell index math,
// cell memory {valid, min z} and the result register. Depends on gclp_pkg.
module gclp_dpath #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    // item fields
    input  logic                i_op,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    input  logic [5:0]          i_cell_col,
    input  logic [5:0]          i_cell_row,
    // control
    input  gclp_pkg::t_cmd      i_cmd,
    output gclp_pkg::t_sts      o_sts,
    // result
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic                o_occupied,
    output logic signed [31:0]  o_center_x,
    output logic signed [31:0]  o_center_y,
    output logic signed [31:0]  o_lowest_z
);

    localparam int CW    = gclp_pkg::COORD_W;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // configuration registers
    logic signed [CW-1:0] r_origin_x;
    logic signed [CW-1:0] r_origin_y;
    logic [4:0]           r_cell_shift;
    logic [6:0]           r_grid_cols;
    logic [6:0]           r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_cell_shift <= gclp_pkg::SHIFT_RESET;
            r_grid_cols  <= gclp_pkg::COLS_RESET;
            r_grid_rows  <= gclp_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gclp_pkg::CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data;
                gclp_pkg::CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data;
                gclp_pkg::CFG_CELL_SHIFT: r_cell_shift <= i_cfg_data[4:0];
                gclp_pkg::CFG_GRID_COLS:  r_grid_cols  <= i_cfg_data[6:0];
                gclp_pkg::CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // saturated settings in use
    logic [4:0] w_shift;
    logic [6:0] w_cols;
    logic [6:0] w_rows;

    assign w_shift = (r_cell_shift > gclp_pkg::MAX_SHIFT) ? gclp_pkg::MAX_SHIFT : r_cell_shift;
    assign w_cols  = (32'(r_grid_cols) > MAX_COLS) ? 7'(MAX_COLS) : r_grid_cols;
    assign w_rows  = (32'(r_grid_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : r_grid_rows;

    // item capture; offsets from the origin taken on accept
    logic                 r_op;
    logic [CW:0]          r_dx;
    logic [CW:0]          r_dy;
    logic signed [31:0]   r_z;
    logic [5:0]           r_col;
    logic [5:0]           r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_dx  <= {i_point_x[CW-1], i_point_x} - {r_origin_x[CW-1], r_origin_x};
            r_dy  <= {i_point_y[CW-1], i_point_y} - {r_origin_y[CW-1], r_origin_y};
            r_z   <= i_point_z;
            r_col <= i_cell_col;
            r_row <= i_cell_row;
        end
    end

    // cell index, range check and centers
    logic [CW:0]    w_tx;
    logic [CW:0]    w_ty;
    logic           w_in_grid;
    logic [AW-1:0]  w_addr;
    logic [CW-1:0]  w_half;

    assign w_tx = (r_op == gclp_pkg::OP_READ) ? (CW+1)'(r_col) : (r_dx >> w_shift);
    assign w_ty = (r_op == gclp_pkg::OP_READ) ? (CW+1)'(r_row) : (r_dy >> w_shift);
    assign w_in_grid = ((r_op == gclp_pkg::OP_READ) || (!r_dx[CW] && !r_dy[CW]))
                       && (w_tx < (CW+1)'(w_cols)) && (w_ty < (CW+1)'(w_rows));
    assign w_addr = AW'(AW'(w_ty[RIW-1:0]) * AW'(MAX_COLS)) + AW'(w_tx[CIW-1:0]);
    // half a cell, rounded down: zero when the shift is zero
    assign w_half = (CW'(1) << w_shift) >> 1;

    logic [AW-1:0]        r_addr;
    logic                 r_in_grid;
    logic signed [CW-1:0] r_center_x;
    logic signed [CW-1:0] r_center_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_addr     <= w_addr;
            r_in_grid  <= w_in_grid;
            r_center_x <= r_origin_x + ((CW'(r_col) << w_shift) | w_half);
            r_center_y <= r_origin_y + ((CW'(r_row) << w_shift) | w_half);
        end
    end

    // cell memory: bit 32 valid, bits 31:0 minimum z
    logic [32:0]   r_mem [DEPTH];
    logic [32:0]   r_rd;
    logic [AW-1:0] r_clr_addr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [32:0]   w_wdata;
    logic          w_lower;
    logic          w_occupied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));

    assign w_lower    = (r_z < $signed(r_rd[31:0]));
    assign w_occupied = r_in_grid && r_rd[32];
    assign w_we       = i_cmd.clr
                        || (i_cmd.finish && r_in_grid
                            && ((r_op == gclp_pkg::OP_READ) || !r_rd[32] || w_lower));
    assign w_waddr    = i_cmd.clr ? r_clr_addr : r_addr;
    // a read clears the cell, an insert keeps the lower z
    assign w_wdata    = (i_cmd.finish && (r_op == gclp_pkg::OP_INSERT)) ? {1'b1, r_z} : '0;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    // result register
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic                r_occupied;
    logic signed [31:0]  r_out_cx;
    logic signed [31:0]  r_out_cy;
    logic signed [31:0]  r_lowest_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_op == gclp_pkg::OP_READ) begin
                r_status   <= gclp_pkg::ST_REPORT;
                r_occupied <= w_occupied;
                r_out_cx   <= r_center_x;
                r_out_cy   <= r_center_y;
                r_lowest_z <= w_occupied ? $signed(r_rd[31:0]) : '0;
            end else begin
                r_status   <= r_in_grid ? gclp_pkg::ST_STORED : gclp_pkg::ST_OUTSIDE;
                r_occupied <= 1'b0;
                r_out_cx   <= '0;
                r_out_cy   <= '0;
                r_lowest_z <= '0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_occupied     = r_occupied;
    assign o_center_x     = r_out_cx;
    assign o_center_y     = r_out_cy;
    assign o_lowest_z     = r_lowest_z;

endmodule

/* src/grid_cell_lowest_point.sv */
`timescale 1ns / 1ps
// Top level of the grid lowest-point filter: sequencer plus datapath.
// Depends on gclp_pkg, gclp_ctrl and gclp_dpath.
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    i_op, i_point_x/y/z, i_cell_col/row
//  output   out        o_out_valid / i_out_stall  o_status, o_occupied, o_center_x/y,
//                                                 o_lowest_z
//  config   in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Each item steps through capture, index/range, memory read, update and result, and the
// next item is taken only after that update, set by the registered read-modify-write
// of the cell memory, with one item in flight at a time.
// After reset a sweep clears all MAX_COLS*MAX_ROWS entries of the cell memory; items
// wait, configuration writes are taken. A stalled result holds the update step;
// the next item is taken while a finished result waits in the output register.
module grid_cell_lowest_point #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    input  logic [5:0]          i_cell_col,
    input  logic [5:0]          i_cell_row,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic                o_occupied,
    output logic signed [31:0]  o_center_x,
    output logic signed [31:0]  o_center_y,
    output logic signed [31:0]  o_lowest_z
);

    gclp_pkg::t_cmd w_cmd;
    gclp_pkg::t_sts w_sts;

    gclp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    gclp_dpath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_occupied  (o_occupied),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_lowest_z  (o_lowest_z)
    );

    // one item in flight: an accepted item closes the input until its result is built
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // a finished item always shows up at the output next cycle
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out_valid)
        else $error("finished item missing at the output");

    // a new result appears only from a finished item
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finished item");

    // no update step or item capture while the memory clearing sweep runs
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |-> (!w_cmd.finish && !w_cmd.load))
        else $error("item work during the clearing sweep");

endmodule

/* tb/sv/tb_grid_cell_lowest_point.sv */
`timescale 1ns / 1ps
// Self-checking testbench for grid_cell_lowest_point: directed and random point/read items
// with random idling on both sides, checked against a built-in lowest-z grid predictor.
// Depends on gclp_pkg and grid_cell_lowest_point.
module tb_grid_cell_lowest_point;

    localparam int GRID_DIM    = 64;
    localparam int GRID_CELLS  = GRID_DIM * GRID_DIM;
    localparam int STALL_LIMIT = 20000;  // covers the clearing sweep after reset
    localparam int SETTLE      = 16;
    localparam int PHASE_ITEMS = 65;

    typedef struct packed {
        logic               op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [5:0]         col;
        logic [5:0]         row;
    } t_cell_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               occupied;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] lowest_z;
    } t_cell_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = gclp_pkg::CFG_ORIGIN_X;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_op = gclp_pkg::OP_INSERT;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic [5:0]         i_cell_col = '0;
    logic [5:0]         i_cell_row = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic               o_occupied;
    logic signed [31:0] o_center_x;
    logic signed [31:0] o_center_y;
    logic signed [31:0] o_lowest_z;

    grid_cell_lowest_point uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_occupied  (o_occupied),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_lowest_z  (o_lowest_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration and the cell store
    logic signed [31:0] m_origin_x = '0;
    logic signed [31:0] m_origin_y = '0;
    logic [4:0]         m_shift = gclp_pkg::SHIFT_RESET;
    logic [6:0]         m_cols = gclp_pkg::COLS_RESET;
    logic [6:0]         m_rows = gclp_pkg::ROWS_RESET;
    bit                 cell_valid [GRID_CELLS];
    logic signed [31:0] cell_low_z [GRID_CELLS];

    t_cell_item   pending_points[$];
    t_cell_report expected_reports[$];
    t_cell_item   on_bus;
    bit           steady_flow = 1'b0;
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           n_inserts = 0;
    int           n_outside = 0;
    int           n_reads = 0;
    int           n_occupied = 0;

    function automatic int unsigned shift_in_use();
        return 32'((m_shift > gclp_pkg::MAX_SHIFT) ? gclp_pkg::MAX_SHIFT : m_shift);
    endfunction

    function automatic int unsigned cols_in_use();
        return (m_cols > GRID_DIM) ? GRID_DIM : 32'(m_cols);
    endfunction

    function automatic int unsigned rows_in_use();
        return (m_rows > GRID_DIM) ? GRID_DIM : 32'(m_rows);
    endfunction

    function automatic logic [31:0] cell_center(input logic signed [31:0] origin,
                                                input logic [5:0] idx);
        int unsigned        s;
        longint unsigned    half;
        longint unsigned    c;
        s = shift_in_use();
        half = (s != 0) ? (64'd1 << (s - 1)) : 64'd0;
        c = longint'(origin) + (longint'(idx) << s) + half;
        return c[31:0];
    endfunction

    // Work out the report for one accepted item and queue it
    function automatic void predict_lowest_point(input t_cell_item it);
        t_cell_report r;
        longint       dx;
        longint       dy;
        longint       tx;
        longint       ty;
        int unsigned  idx;
        r = '0;
        if (it.op == gclp_pkg::OP_INSERT) begin
            dx = longint'(it.x) - longint'(m_origin_x);
            dy = longint'(it.y) - longint'(m_origin_y);
            r.status = gclp_pkg::ST_STORED;
            if (dx < 0 || dy < 0) begin
                r.status = gclp_pkg::ST_OUTSIDE;
            end else begin
                tx = dx >>> shift_in_use();
                ty = dy >>> shift_in_use();
                if (tx >= cols_in_use() || ty >= rows_in_use()) begin
                    r.status = gclp_pkg::ST_OUTSIDE;
                end else begin
                    idx = int'(ty) * GRID_DIM + int'(tx);
                    // keep the old minimum on equal z
                    if (!cell_valid[idx] || it.z < cell_low_z[idx]) begin
                        cell_valid[idx] = 1'b1;
                        cell_low_z[idx] = it.z;
                    end
                end
            end
        end else begin
            r.status   = gclp_pkg::ST_REPORT;
            r.center_x = cell_center(m_origin_x, it.col);
            r.center_y = cell_center(m_origin_y, it.row);
            if (it.col < cols_in_use() && it.row < rows_in_use()) begin
                idx = it.row * GRID_DIM + it.col;
                if (cell_valid[idx]) begin
                    r.occupied = 1'b1;
                    r.lowest_z = cell_low_z[idx];
                end
                cell_valid[idx] = 1'b0;
            end
        end
        expected_reports = {expected_reports, r};
    endfunction

    function automatic logic take_break();
        return !steady_flow && ($urandom_range(99) < 22);
    endfunction

    // Mostly a few hot cells, so repeated hits on one cell come back to back
    function automatic int unsigned pick_index(input int unsigned n);
        if ($urandom_range(1) == 0)
            return $urandom_range((n < 4) ? n - 1 : 3);
        return $urandom_range(n - 1);
    endfunction

    function automatic t_cell_item random_item();
        t_cell_item   it;
        int unsigned  roll;
        int unsigned  cols;
        int unsigned  rows;
        int unsigned  s;
        longint       span_mask;
        cols = cols_in_use();
        rows = rows_in_use();
        s = shift_in_use();
        span_mask = (longint'(1) << s) - 1;
        it.op  = gclp_pkg::OP_INSERT;
        it.x   = $urandom;
        it.y   = $urandom;
        it.z   = $urandom;
        it.col = 6'($urandom);
        it.row = 6'($urandom);
        if ($urandom_range(2) == 0)
            it.z = int'($urandom_range(8)) - 4;
        roll = $urandom_range(99);
        if (roll < 25) begin
            it.op = gclp_pkg::OP_READ;
            if (cols != 0 && rows != 0 && $urandom_range(4) != 0) begin
                it.col = 6'(pick_index(cols));
                it.row = 6'(pick_index(rows));
            end
        end else if (roll < 88 && cols != 0 && rows != 0) begin
            it.x = 32'(longint'(m_origin_x) + (longint'(pick_index(cols)) << s)
                       + ($urandom & span_mask));
            it.y = 32'(longint'(m_origin_y) + (longint'(pick_index(rows)) << s)
                       + ($urandom & span_mask));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z);
        t_cell_item it;
        it = '0;
        it.op = gclp_pkg::OP_INSERT;
        it.x = x;
        it.y = y;
        it.z = z;
        it.col = 6'($urandom);
        it.row = 6'($urandom);
        pending_points = {pending_points, it};
    endtask

    task automatic push_read(input logic [5:0] col, input logic [5:0] row);
        t_cell_item it;
        it = '0;
        it.op = gclp_pkg::OP_READ;
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        it.col = col;
        it.row = row;
        pending_points = {pending_points, it};
    endtask

    task automatic push_random(input int n);
        @(negedge i_clk);
        repeat (n) pending_points = {pending_points, random_item()};
    endtask

    // Hold until every item has gone in and every report has come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_points.size() != 0 || i_in_valid || expected_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            gclp_pkg::CFG_ORIGIN_X:   m_origin_x = data;
            gclp_pkg::CFG_ORIGIN_Y:   m_origin_y = data;
            gclp_pkg::CFG_CELL_SHIFT: m_shift = data[4:0];
            gclp_pkg::CFG_GRID_COLS:  m_cols = data[6:0];
            gclp_pkg::CFG_GRID_ROWS:  m_rows = data[6:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] shift, input logic [31:0] cols,
                            input logic [31:0] rows);
        write_reg(gclp_pkg::CFG_ORIGIN_X, ox);
        write_reg(gclp_pkg::CFG_ORIGIN_Y, oy);
        write_reg(gclp_pkg::CFG_CELL_SHIFT, shift);
        write_reg(gclp_pkg::CFG_GRID_COLS, cols);
        write_reg(gclp_pkg::CFG_GRID_ROWS, rows);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Input driver: hold the item until taken, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_lowest_point(on_bus);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_points.size() != 0 && !take_break()) begin
                    on_bus = pending_points.pop_front();
                    i_op       <= on_bus.op;
                    i_point_x  <= on_bus.x;
                    i_point_y  <= on_bus.y;
                    i_point_z  <= on_bus.z;
                    i_cell_col <= on_bus.col;
                    i_cell_row <= on_bus.row;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and stall source
    always @(posedge i_clk) begin
        t_cell_report want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(o_status), 32'd0);
                end else begin
                    want = expected_reports.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_occupied !== want.occupied)
                        report_mismatch("occupied", 32'(o_occupied), 32'(want.occupied));
                    if (o_center_x !== want.center_x)
                        report_mismatch("center_x", o_center_x, want.center_x);
                    if (o_center_y !== want.center_y)
                        report_mismatch("center_y", o_center_y, want.center_y);
                    if (o_lowest_z !== want.lowest_z)
                        report_mismatch("lowest_z", o_lowest_z, want.lowest_z);
                    case (want.status)
                        gclp_pkg::ST_STORED:  n_inserts++;
                        gclp_pkg::ST_OUTSIDE: begin
                            n_inserts++;
                            n_outside++;
                        end
                        default: begin
                            n_reads++;
                            if (want.occupied)
                                n_occupied++;
                        end
                    endcase
                end
            end
            i_out_stall <= take_break();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset grid: origin 0, 256-unit cells, 64 x 64
        @(negedge i_clk);
        push_point(0, 0, 32'sh7FFF_FFFF);
        push_point(10, 20, 32'sh8000_0000);
        push_point(5, 5, 32'sh8000_0000);          // equal z, cell unchanged
        push_point(255, 255, 0);
        push_read(0, 0);
        push_read(0, 0);                           // cleared by the read before
        push_point(-1, 0, 0);
        push_point(0, -1, 0);
        push_point(16384, 0, 0);                   // one column past the grid
        push_point(16383, 16383, -7);
        push_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
        push_point(32'sh8000_0000, 32'sh8000_0000, 1);
        push_point(16383, 300, 32'sh7FFF_FFFF);
        push_read(63, 63);
        push_read(63, 1);
        push_read(63, 0);
        push_point(256, 512, 3);
        push_point(257, 513, 3);
        push_point(258, 514, 2);
        push_read(1, 2);
        drain();

        set_grid($urandom, $urandom, 4, 16, 8);
        @(negedge i_clk);
        push_read(63, 63);                         // read outside the grid in use
        push_read(16, 7);
        push_read(3, 40);
        push_random(PHASE_ITEMS);
        drain();

        set_grid(32'h8000_0000, 32'h7FFF_FC00, 0, 64, 64);
        push_random(PHASE_ITEMS);
        drain();

        // shift and grid size above their limits saturate
        set_grid($urandom, $urandom, 31, 127, 100);
        push_random(PHASE_ITEMS);
        drain();

        // centers wrap past the top of the coordinate range
        set_grid(32'h7FFF_FF00, 32'hFFFF_FFFB, 24, 1, 1);
        push_random(PHASE_ITEMS);
        drain();

        // zero columns puts every point outside
        set_grid(-1000, -1000, 2, 0, 5);
        push_random(PHASE_ITEMS);
        drain();

        set_grid($urandom, $urandom, 6, 64, 64);
        steady_flow = 1'b1;
        push_random(PHASE_ITEMS / 2);
        drain();
        steady_flow = 1'b0;
        push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        $display("Checked %0d inserts (%0d outside the grid) and %0d cell reads (%0d occupied)",
                 n_inserts, n_outside, n_reads, n_occupied);
        $display("across seven grid settings with random stalls on both channels");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
src/gclp_pkg.sv
src/gclp_ctrl.sv
src/gclp_dpath.sv
src/grid_cell_lowest_point.sv
tb/sv/tb_grid_cell_lowest_point.sv
